[rtl/iias_pkg.sv]
// ----------------------------------------------------------------------------
// iias_pkg
// Shared sizes, register indexes and controller/datapath command types for
// the integral image area sum block.
// ----------------------------------------------------------------------------
package iias_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int PIXEL_BITS = 8;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
    localparam int TABLE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int PIXEL_FIELD_BITS = 8;
    localparam int COORD_BITS       = 6;
    localparam int ENTRY_BITS       = 21;
    localparam int SUM_BITS         = 20;

    localparam int CFG_BITS     = 7;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] SIZE_RESET_WIDTH  = CFG_BITS'(MAX_WIDTH);
    localparam logic [CFG_BITS-1:0] SIZE_RESET_HEIGHT = CFG_BITS'(MAX_HEIGHT);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        RD_IN,
        RD_B,
        RD_C,
        RD_D
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    acc_set;
        logic    acc_sub;
        logic    commit_load;
        logic    commit_query;
    } t_dp_cmd;

    typedef struct packed {
        logic in_query;
    } t_dp_stat;

    // register value clamped to 1..max
    function automatic logic [CFG_BITS-1:0] eff_size(
        input logic [CFG_BITS-1:0] value,
        input logic [CFG_BITS-1:0] max_value
    );
        logic [CFG_BITS-1:0] result;
        if (value == '0) begin
            result = CFG_BITS'(1);
        end else if (value > max_value) begin
            result = max_value;
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage

[rtl/iias_req_if.sv]
// ----------------------------------------------------------------------------
// iias_req_if
// Request channel: pixel loads and area queries.
// ----------------------------------------------------------------------------
interface iias_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [iias_pkg::PIXEL_FIELD_BITS-1:0] pixel;
    logic [iias_pkg::COORD_BITS-1:0]       corner_x0;
    logic [iias_pkg::COORD_BITS-1:0]       corner_y0;
    logic [iias_pkg::COORD_BITS-1:0]       corner_x1;
    logic [iias_pkg::COORD_BITS-1:0]       corner_y1;

    modport source (
        output valid, operation, pixel, corner_x0, corner_y0, corner_x1, corner_y1,
        input  ready
    );
    modport sink (
        input  valid, operation, pixel, corner_x0, corner_y0, corner_x1, corner_y1,
        output ready
    );
endinterface

[rtl/iias_rsp_if.sv]
// ----------------------------------------------------------------------------
// iias_rsp_if
// Response channel: integral value or area sum with flags.
// ----------------------------------------------------------------------------
interface iias_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [iias_pkg::SUM_BITS-1:0] sum_value;
    logic                          image_done;
    logic                          range_error;

    modport source (
        output valid, sum_value, image_done, range_error,
        input  ready
    );
    modport sink (
        input  valid, sum_value, image_done, range_error,
        output ready
    );
endinterface

[rtl/iias_datapath.sv]
// ----------------------------------------------------------------------------
// iias_datapath
// Summed-area table memory, raster position, running row sum, query
// accumulator, size registers and result register.
// ----------------------------------------------------------------------------
module iias_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iias_pkg::t_dp_cmd                     i_cmd,
    output iias_pkg::t_dp_stat                    o_stat,
    input  logic                                  i_cfg_we,
    input  logic [iias_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [iias_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                  i_operation,
    input  logic [iias_pkg::PIXEL_FIELD_BITS-1:0] i_pixel,
    input  logic [iias_pkg::COORD_BITS-1:0]       i_corner_x0,
    input  logic [iias_pkg::COORD_BITS-1:0]       i_corner_y0,
    input  logic [iias_pkg::COORD_BITS-1:0]       i_corner_x1,
    input  logic [iias_pkg::COORD_BITS-1:0]       i_corner_y1,
    output logic [iias_pkg::SUM_BITS-1:0]         o_sum_value,
    output logic                                  o_image_done,
    output logic                                  o_range_error
);

    logic [iias_pkg::ENTRY_BITS-1:0] r_table [iias_pkg::TABLE_DEPTH];
    logic [iias_pkg::ENTRY_BITS-1:0] r_rdata;

    logic [iias_pkg::CFG_BITS-1:0]   r_width;
    logic [iias_pkg::CFG_BITS-1:0]   r_height;
    logic [iias_pkg::COL_BITS-1:0]   r_col;
    logic [iias_pkg::ROW_BITS-1:0]   r_row;
    logic [iias_pkg::ENTRY_BITS-1:0] r_rrs;

    logic [iias_pkg::PIXEL_BITS-1:0] r_pix;
    logic [iias_pkg::COORD_BITS-1:0] r_x0;
    logic [iias_pkg::COORD_BITS-1:0] r_y0;
    logic [iias_pkg::COORD_BITS-1:0] r_x1;
    logic [iias_pkg::COORD_BITS-1:0] r_y1;
    logic                            r_qerr;
    logic [iias_pkg::ENTRY_BITS-1:0] r_acc;

    logic [iias_pkg::SUM_BITS-1:0]   r_sum;
    logic                            r_done;
    logic                            r_err;

    logic [iias_pkg::CFG_BITS-1:0]   w_eff;
    logic [iias_pkg::CFG_BITS-1:0]   h_eff;
    logic [iias_pkg::ADDR_BITS-1:0]  rd_addr;
    logic [iias_pkg::ADDR_BITS-1:0]  wr_addr;
    logic [iias_pkg::ENTRY_BITS-1:0] n_rrs;
    logic [iias_pkg::ENTRY_BITS-1:0] above;
    logic [iias_pkg::ENTRY_BITS-1:0] entry;
    logic [iias_pkg::ENTRY_BITS-1:0] area;
    logic [iias_pkg::CFG_BITS-1:0]   col_inc;
    logic [iias_pkg::CFG_BITS-1:0]   row_inc;
    logic                            row_end;
    logic                            img_end;
    logic                            in_err;

    assign w_eff = iias_pkg::eff_size(r_width, iias_pkg::SIZE_RESET_WIDTH);
    assign h_eff = iias_pkg::eff_size(r_height, iias_pkg::SIZE_RESET_HEIGHT);

    assign o_stat.in_query = (i_operation == iias_pkg::OP_QUERY);

    always_comb begin
        case (i_cmd.rd_sel)
            iias_pkg::RD_IN: begin
                if (i_operation == iias_pkg::OP_QUERY) begin
                    rd_addr = {i_corner_y1, i_corner_x1};
                end else begin
                    rd_addr = {r_row - 1'b1, r_col};
                end
            end
            iias_pkg::RD_B: rd_addr = {r_y0, r_x1};
            iias_pkg::RD_C: rd_addr = {r_y1, r_x0};
            iias_pkg::RD_D: rd_addr = {r_y0, r_x0};
            default:        rd_addr = {r_y0, r_x0};
        endcase
    end

    assign in_err = ({1'b0, i_corner_x0} >= w_eff) || ({1'b0, i_corner_x1} >= w_eff)
                 || ({1'b0, i_corner_y0} >= h_eff) || ({1'b0, i_corner_y1} >= h_eff);

    // new table entry from running row sum and entry above
    assign wr_addr = {r_row, r_col};
    assign n_rrs   = ((r_col == '0) ? '0 : r_rrs) + iias_pkg::ENTRY_BITS'(r_pix);
    assign above   = (r_row != '0) ? r_rdata : '0;
    assign entry   = n_rrs + above;
    assign area    = r_acc + r_rdata;

    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;
    assign row_end = (col_inc >= w_eff);
    assign img_end = row_end && (row_inc >= h_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_load) begin
            r_table[wr_addr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= iias_pkg::SIZE_RESET_WIDTH;
            r_height <= iias_pkg::SIZE_RESET_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
            r_rrs    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    iias_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    iias_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit_load) begin
                r_rrs <= n_rrs;
                if (row_end) begin
                    r_col <= '0;
                    if (img_end) begin
                        r_row <= '0;
                    end else begin
                        r_row <= row_inc[iias_pkg::ROW_BITS-1:0];
                    end
                end else begin
                    r_col <= col_inc[iias_pkg::COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix  <= i_pixel[iias_pkg::PIXEL_BITS-1:0];
            r_x0   <= i_corner_x0;
            r_y0   <= i_corner_y0;
            r_x1   <= i_corner_x1;
            r_y1   <= i_corner_y1;
            r_qerr <= in_err;
        end
        if (i_cmd.acc_set) begin
            r_acc <= r_rdata;
        end else if (i_cmd.acc_sub) begin
            r_acc <= r_acc - r_rdata;
        end
        if (i_cmd.commit_load) begin
            r_sum  <= entry[iias_pkg::SUM_BITS-1:0];
            r_done <= img_end;
            r_err  <= 1'b0;
        end else if (i_cmd.commit_query) begin
            r_sum  <= r_qerr ? '0 : area[iias_pkg::SUM_BITS-1:0];
            r_done <= 1'b0;
            r_err  <= r_qerr;
        end
    end

    assign o_sum_value   = r_sum;
    assign o_image_done  = r_done;
    assign o_range_error = r_err;

endmodule

[rtl/iias_ctrl.sv]
// ----------------------------------------------------------------------------
// iias_ctrl
// Sequencer for table reads and writes; owns the channel handshakes and the
// result valid flag.
// ----------------------------------------------------------------------------
module iias_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  iias_pkg::t_dp_stat i_stat,
    output iias_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_Q1,
        S_Q2,
        S_Q3,
        S_QFIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;
    logic   commit;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign commit     = o_cmd.commit_load || o_cmd.commit_query;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = iias_pkg::RD_IN;
                    n_state       = i_stat.in_query ? S_Q1 : S_LOAD;
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    o_cmd.commit_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_Q1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = iias_pkg::RD_B;
                o_cmd.acc_set = 1'b1;
                n_state       = S_Q2;
            end
            S_Q2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = iias_pkg::RD_C;
                o_cmd.acc_sub = 1'b1;
                n_state       = S_Q3;
            end
            S_Q3: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = iias_pkg::RD_D;
                o_cmd.acc_sub = 1'b1;
                n_state       = S_QFIN;
            end
            S_QFIN: begin
                if (slot_free) begin
                    o_cmd.commit_query = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/integral_image_area_sum.sv]
// ----------------------------------------------------------------------------
// integral_image_area_sum
// Builds a summed-area table from raster-order pixels and answers
// rectangle area queries from it.
//
// i_req carries one item per transfer: a pixel load (operation 0) or an
// area query (operation 1) with corners (x0,y0) and (x1,y1). o_rsp returns
// one result per item: the new table entry with image_done on the last
// pixel, or the area sum, with range_error and a zero sum when a corner
// lies outside the configured size. Sizes are to be written on the i_cfg_*
// port only while the block is idle; the block itself does not enforce this.
// A value of 0 acts as 1, above 64 acts as 64. A load reads the entry above
// and then writes; a query reads four corners, one per cycle. Items are
// taken one at a time; the result register lets the next item start while a
// result still waits. If o_rsp stalls, the next item holds at its final step
// until the result register frees up. Reset clears position, running sum and
// sizes (64 x 64); no memory sweep.
// ----------------------------------------------------------------------------
module integral_image_area_sum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    iias_req_if.sink                          i_req,
    iias_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [iias_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [iias_pkg::CFG_BITS-1:0]     i_cfg_data
);

    iias_pkg::t_dp_cmd  dp_cmd;
    iias_pkg::t_dp_stat dp_stat;
    logic               in_ready;
    logic               out_valid;

    iias_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    iias_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_req.operation),
        .i_pixel       (i_req.pixel),
        .i_corner_x0   (i_req.corner_x0),
        .i_corner_y0   (i_req.corner_y0),
        .i_corner_x1   (i_req.corner_x1),
        .i_corner_y1   (i_req.corner_y1),
        .o_sum_value   (o_rsp.sum_value),
        .o_image_done  (o_rsp.image_done),
        .o_range_error (o_rsp.range_error)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule
